// ===== design/ffsa_pkg.sv =====
`default_nettype none
package ffsa_pkg;

    // table and pool dimensions
    localparam int MAX_SEGMENTS = 16;
    localparam int POOL_UNITS   = 512;

    // segment start and size width, wide enough to hold the whole pool
    localparam int SZ_W  = $clog2(POOL_UNITS + 1);
    // width used for compares against the 10-bit request size
    localparam int CMP_W = (SZ_W > 10) ? SZ_W : 10;

    localparam logic [SZ_W-1:0] POOL_SIZE = SZ_W'(POOL_UNITS);

    // result status codes
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_RELEASED = 3'd2;
    localparam logic [2:0] ST_NOOWNER  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // input transaction
    typedef struct packed {
        logic       cmd;
        logic [7:0] owner_id;
        logic [9:0] request_size;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [2:0] status;
        logic [8:0] start_unit;
        logic [9:0] granted_units;
    } t_out;

    // one table entry, held in one cell
    typedef struct packed {
        logic            valid;
        logic [SZ_W-1:0] start;
        logic [SZ_W-1:0] size;
        logic            free;
        logic [7:0]      owner;
    } t_seg;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_MARK  = 2'd2,
        OP_MERGE = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] owner;
        logic [9:0] want;
        logic       full;
    } t_bcast;

    // chain handed from each cell to the next one up
    typedef struct packed {
        logic taken;   // an earlier cell was hit (alloc) or merged (merge)
        logic split;   // the hit cell needs a split
        logic hit;     // the cell just below was the hit cell
    } t_chain;

endpackage
`default_nettype wire

// ===== design/ffsa_cell.sv =====
`default_nettype none
module ffsa_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ffsa_pkg::t_seg    i_init,
    input  ffsa_pkg::t_bcast  i_bc,
    input  ffsa_pkg::t_seg    i_left,
    input  ffsa_pkg::t_seg    i_right,
    input  ffsa_pkg::t_chain  i_chain,
    output ffsa_pkg::t_chain  o_chain,
    output ffsa_pkg::t_seg    o_seg,
    output logic              o_hit,
    output logic              o_match
);

    localparam int CW = ffsa_pkg::CMP_W;
    localparam int SW = ffsa_pkg::SZ_W;

    ffsa_pkg::t_seg r_seg;
    ffsa_pkg::t_seg n_seg;

    logic [CW-1:0] size_ext;
    logic [CW-1:0] want_ext;
    logic [CW-1:0] left_start_ext;
    logic [CW-1:0] left_size_ext;
    logic          fit;
    logic          hit;
    logic          split_here;
    logic          do_shift;
    logic          pair;

    assign size_ext       = CW'(r_seg.size);
    assign want_ext       = CW'(i_bc.want);
    assign left_start_ext = CW'(i_left.start);
    assign left_size_ext  = CW'(i_left.size);

    // first-fit candidate and owner match
    assign fit        = r_seg.valid & r_seg.free & (i_bc.want != 10'd0) & (size_ext >= want_ext);
    assign hit        = fit & ~i_chain.taken;
    assign split_here = hit & (size_ext > want_ext);
    assign do_shift   = i_chain.split & ~i_bc.full;
    assign o_match    = r_seg.valid & ~r_seg.free & (r_seg.owner == i_bc.owner);

    // adjacent free pair with the neighbour above
    assign pair = r_seg.valid & r_seg.free & i_right.valid & i_right.free;

    assign o_hit = (i_bc.op == ffsa_pkg::OP_ALLOC) & hit;
    assign o_seg = r_seg;

    // chain to the next cell
    always_comb begin
        o_chain = '0;
        case (i_bc.op)
            ffsa_pkg::OP_ALLOC: begin
                o_chain.taken = i_chain.taken | fit;
                o_chain.split = hit ? split_here : i_chain.split;
                o_chain.hit   = hit;
            end
            ffsa_pkg::OP_MERGE: begin
                o_chain.taken = i_chain.taken | pair;
            end
            default: begin
                o_chain = '0;
            end
        endcase
    end

    // entry update
    always_comb begin
        n_seg = r_seg;
        case (i_bc.op)
            ffsa_pkg::OP_ALLOC: begin
                if (hit) begin
                    if (!(split_here && i_bc.full)) begin
                        n_seg.size  = SW'(want_ext);
                        n_seg.free  = 1'b0;
                        n_seg.owner = i_bc.owner;
                    end
                end else if (i_chain.hit && do_shift) begin
                    // remainder of the split segment below
                    n_seg.valid = 1'b1;
                    n_seg.start = SW'(left_start_ext + want_ext);
                    n_seg.size  = SW'(left_size_ext - want_ext);
                    n_seg.free  = 1'b1;
                    n_seg.owner = 8'd0;
                end else if (i_chain.taken && do_shift) begin
                    n_seg = i_left;
                end
            end
            ffsa_pkg::OP_MARK: begin
                if (o_match) begin
                    n_seg.free  = 1'b1;
                    n_seg.owner = 8'd0;
                end
            end
            ffsa_pkg::OP_MERGE: begin
                if (i_chain.taken) begin
                    n_seg = i_right;
                end else if (pair) begin
                    n_seg.size = SW'(r_seg.size + i_right.size);
                end
            end
            default: begin
                n_seg = r_seg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= i_init;
        end else begin
            r_seg <= n_seg;
        end
    end

endmodule
`default_nettype wire

// ===== design/first_fit_segment_allocator_unit.sv =====
// allocate: request and result each registered; the next input is taken only back in idle
// free: owner's segments marked free in the exec state, then m merges (0 to 15) in the merge state,
//   one merge of two adjacent free segments per cycle in the cell row; then result registered
// free of an owner that holds nothing: no-owner result registered straight from the exec state
// a waiting result holds the block before its update step, the next input is still taken
// synchronous reset returns the table to one free segment covering the whole pool
`default_nettype none
module first_fit_segment_allocator_unit (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  ffsa_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output ffsa_pkg::t_out   o_out_data
);

    localparam int N  = ffsa_pkg::MAX_SEGMENTS;
    localparam int CW = ffsa_pkg::CMP_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_MERGE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    ffsa_pkg::t_in    r_req;
    ffsa_pkg::t_out   r_out;
    ffsa_pkg::t_out   n_out;
    logic             r_out_valid;
    logic             n_out_valid;

    ffsa_pkg::t_bcast w_bc;
    ffsa_pkg::t_seg   w_seg   [N];
    ffsa_pkg::t_seg   w_left  [N];
    ffsa_pkg::t_seg   w_right [N];
    ffsa_pkg::t_seg   w_init  [N];
    ffsa_pkg::t_chain w_chain [N+1];
    logic [N-1:0]     w_hit;
    logic [N-1:0]     w_match;

    logic             out_free;
    logic             load;
    logic [CW-1:0]    hit_start;

    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_chain[0] = '0;

    // broadcast to the cell row
    always_comb begin
        w_bc.owner = r_req.owner_id;
        w_bc.want  = r_req.request_size;
        w_bc.full  = w_seg[N-1].valid;
        w_bc.op    = ffsa_pkg::OP_HOLD;
        case (r_state)
            S_EXEC: begin
                if (out_free) begin
                    w_bc.op = (r_req.cmd == ffsa_pkg::CMD_ALLOC) ? ffsa_pkg::OP_ALLOC
                                                                 : ffsa_pkg::OP_MARK;
                end
            end
            S_MERGE: begin
                w_bc.op = ffsa_pkg::OP_MERGE;
            end
            default: begin
                w_bc.op = ffsa_pkg::OP_HOLD;
            end
        endcase
    end

    // row of segment cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g]       = '0;
            assign w_init[g].valid = 1'b1;
            assign w_init[g].start = '0;
            assign w_init[g].size  = ffsa_pkg::POOL_SIZE;
            assign w_init[g].free  = 1'b1;
            assign w_init[g].owner = 8'd0;
        end else begin : g_rest
            assign w_left[g] = w_seg[g-1];
            assign w_init[g] = '0;
        end
        if (g == N - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid
            assign w_right[g] = w_seg[g+1];
        end

        ffsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_init  (w_init[g]),
            .i_bc    (w_bc),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_seg   (w_seg[g]),
            .o_hit   (w_hit[g]),
            .o_match (w_match[g])
        );
    end

    // start of the hit segment
    always_comb begin
        hit_start = '0;
        for (int k = 0; k < N; k++) begin
            hit_start = hit_start | (w_hit[k] ? CW'(w_seg[k].start) : '0);
        end
    end

    // sequencing and result
    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    if (r_req.cmd == ffsa_pkg::CMD_ALLOC) begin
                        load    = 1'b1;
                        n_state = S_IDLE;
                        n_out   = '0;
                        if (!w_chain[N].taken) begin
                            n_out.status = ffsa_pkg::ST_NOFIT;
                        end else if (w_chain[N].split && w_bc.full) begin
                            n_out.status = ffsa_pkg::ST_FULL;
                        end else begin
                            n_out.status        = ffsa_pkg::ST_GRANTED;
                            n_out.start_unit    = hit_start[8:0];
                            n_out.granted_units = r_req.request_size;
                        end
                    end else if (|w_match) begin
                        n_state = S_MERGE;
                    end else begin
                        load         = 1'b1;
                        n_state      = S_IDLE;
                        n_out        = '0;
                        n_out.status = ffsa_pkg::ST_NOOWNER;
                    end
                end
            end
            S_MERGE: begin
                if (!w_chain[N].taken && out_free) begin
                    load         = 1'b1;
                    n_state      = S_IDLE;
                    n_out        = '0;
                    n_out.status = ffsa_pkg::ST_RELEASED;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = load | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in_data;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== dv/first_fit_segment_allocator_checker.sv =====
`timescale 1ns / 1ps
module first_fit_segment_allocator_checker (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_in_ready,
    input  ffsa_pkg::t_in  i_in_data,
    input  wire            i_out_valid,
    input  wire            i_out_ready,
    input  ffsa_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_checked,
    output int             o_grants,
    output int             o_releases,
    output int             o_full
);

    import ffsa_pkg::*;

    // shadow copy of the segment table
    logic [9:0] seg_base    [MAX_SEGMENTS];
    logic [9:0] seg_len     [MAX_SEGMENTS];
    logic       seg_is_free [MAX_SEGMENTS];
    logic [7:0] seg_holder  [MAX_SEGMENTS];
    int         seg_used;

    // answers predicted for accepted requests, oldest first
    t_out pending_answers [$];

    int fails    = 0;
    int checked  = 0;
    int grants   = 0;
    int releases = 0;
    int fulls    = 0;

    task automatic blank_entry(input int k);
        seg_base[k]    = '0;
        seg_len[k]     = '0;
        seg_is_free[k] = 1'b0;
        seg_holder[k]  = '0;
    endtask

    task automatic move_entry(input int dst, input int src);
        seg_base[dst]    = seg_base[src];
        seg_len[dst]     = seg_len[src];
        seg_is_free[dst] = seg_is_free[src];
        seg_holder[dst]  = seg_holder[src];
    endtask

    // one free segment spanning the whole pool
    task automatic clear_table();
        int k;
        for (k = 0; k < MAX_SEGMENTS; k++) begin
            blank_entry(k);
        end
        seg_len[0]     = 10'(POOL_UNITS);
        seg_is_free[0] = 1'b1;
        seg_used       = 1;
    endtask

    // first fit over the table, split off the remainder behind the grant
    task automatic predict_allocate(input logic [7:0] who, input logic [9:0] want,
                                    output t_out res);
        int hit;
        int k;
        res        = '0;
        res.status = ST_NOFIT;
        hit        = -1;
        if (want != 10'd0) begin
            for (k = 0; k < seg_used; k++) begin
                if (hit < 0 && seg_is_free[k] && seg_len[k] >= want) begin
                    hit = k;
                end
            end
        end
        if (hit >= 0) begin
            if (seg_len[hit] > want && seg_used >= MAX_SEGMENTS) begin
                // a split is needed but there is no room for the remainder
                res.status = ST_FULL;
            end else begin
                if (seg_len[hit] > want) begin
                    for (k = seg_used; k > hit + 1; k--) begin
                        move_entry(k, k - 1);
                    end
                    seg_base[hit + 1]    = seg_base[hit] + want;
                    seg_len[hit + 1]     = seg_len[hit] - want;
                    seg_is_free[hit + 1] = 1'b1;
                    seg_holder[hit + 1]  = '0;
                    seg_used++;
                    seg_len[hit] = want;
                end
                seg_is_free[hit]  = 1'b0;
                seg_holder[hit]   = who;
                res.status        = ST_GRANTED;
                res.start_unit    = seg_base[hit][8:0];
                res.granted_units = seg_len[hit];
            end
        end
    endtask

    // release every segment of the owner, then fold runs of free segments
    task automatic predict_release(input logic [7:0] who, output t_out res);
        bit found;
        int w;
        int k;
        found = 1'b0;
        res   = '0;
        for (k = 0; k < seg_used; k++) begin
            if (!seg_is_free[k] && seg_holder[k] == who) begin
                seg_is_free[k] = 1'b1;
                seg_holder[k]  = '0;
                found          = 1'b1;
            end
        end
        if (!found) begin
            res.status = ST_NOOWNER;
        end else begin
            w = 0;
            for (k = 0; k < seg_used; k++) begin
                if (w > 0 && seg_is_free[w - 1] && seg_is_free[k]) begin
                    seg_len[w - 1] = seg_len[w - 1] + seg_len[k];
                end else begin
                    if (w != k) begin
                        move_entry(w, k);
                    end
                    w++;
                end
            end
            for (k = w; k < MAX_SEGMENTS; k++) begin
                blank_entry(k);
            end
            seg_used   = w;
            res.status = ST_RELEASED;
        end
    endtask

    // result side is checked before the request side of the same edge
    always @(posedge i_clk) begin : watch_channels
        t_out expected;
        t_out predicted;
        if (!i_rst_n) begin
            clear_table();
            pending_answers.delete();
        end else begin
            if ($isunknown(i_out_valid) || $isunknown(i_in_ready)) begin
                $display("%0t handshake unknown: expected 0 or 1, got out_valid %b in_ready %b",
                         $time, i_out_valid, i_in_ready);
                fails++;
            end
            // result transaction
            if (i_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t unexpected result: expected none, got status %0d start %0d units %0d",
                             $time, i_out_data.status, i_out_data.start_unit,
                             i_out_data.granted_units);
                    fails++;
                end else begin
                    expected = pending_answers.pop_front();
                    checked++;
                    case (expected.status)
                        ST_GRANTED:  grants++;
                        ST_RELEASED: releases++;
                        ST_FULL:     fulls++;
                        default: ;
                    endcase
                    if (i_out_data.status !== expected.status) begin
                        $display("%0t status mismatch: expected %0d, got %0d",
                                 $time, expected.status, i_out_data.status);
                        fails++;
                    end
                    if (i_out_data.start_unit !== expected.start_unit) begin
                        $display("%0t start_unit mismatch: expected %0d, got %0d",
                                 $time, expected.start_unit, i_out_data.start_unit);
                        fails++;
                    end
                    if (i_out_data.granted_units !== expected.granted_units) begin
                        $display("%0t granted_units mismatch: expected %0d, got %0d",
                                 $time, expected.granted_units, i_out_data.granted_units);
                        fails++;
                    end
                end
            end
            // request transaction
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.cmd == CMD_ALLOC) begin
                    predict_allocate(i_in_data.owner_id, i_in_data.request_size, predicted);
                end else begin
                    predict_release(i_in_data.owner_id, predicted);
                end
                pending_answers.push_back(predicted);
            end
        end
        o_pending    <= pending_answers.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_grants     <= grants;
        o_releases   <= releases;
        o_full       <= fulls;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

    import ffsa_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int TIMEOUT_NS       = 20_000_000;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int fail_count;
    int pending;
    int checked;
    int grants;
    int releases;
    int fulls;

    int tx_max_gap    = 12;
    int rx_max_gap    = 12;
    int hold_requests = 0;
    int sent_count    = 0;

    first_fit_segment_allocator_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    first_fit_segment_allocator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_grants     (grants),
        .o_releases   (releases),
        .o_full       (fulls)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // overall time limit
    initial begin
        #(TIMEOUT_NS);
        $display("%0t run timed out with %0d results outstanding", $time, pending);
        $display("Verification failed");
        $finish;
    end

    // offer one request transaction after a random gap and hold it until taken
    task automatic push_request(input t_in item);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic alloc_req(input logic [7:0] who, input logic [9:0] units);
        t_in item;
        item.cmd          = CMD_ALLOC;
        item.owner_id     = who;
        item.request_size = units;
        push_request(item);
    endtask

    // size field is a don't-care on free, so it carries noise
    task automatic free_req(input logic [7:0] who);
        t_in item;
        item.cmd          = CMD_FREE;
        item.owner_id     = who;
        item.request_size = 10'($urandom_range(0, 1023));
        push_request(item);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // corner cases: zero size, oversize, whole pool, full table, exact fits, merges
    task automatic run_directed();
        int k;
        alloc_req(8'h00, 10'd0);
        alloc_req(8'h01, 10'd1023);
        alloc_req(8'hFF, 10'd512);
        alloc_req(8'h02, 10'd1);
        free_req(8'hFF);
        // nothing owned by owner zero yet, free segments must not match
        free_req(8'h00);
        // fill all sixteen entries with small segments
        for (k = 0; k < MAX_SEGMENTS - 1; k++) begin
            alloc_req((k % 3 == 1) ? 8'h5A : 8'h00, 10'(k + 1));
        end
        alloc_req(8'hC8, 10'd100);
        // holes without a merge, table stays full
        free_req(8'h5A);
        alloc_req(8'h4D, 10'd1);
        alloc_req(8'h4D, 10'd2);
        alloc_req(8'hC9, 10'd392);
        free_req(8'h00);
        free_req(8'h4D);
        free_req(8'hC9);
    endtask

    // episodes over a small set of owners, closed by freeing each of them
    task automatic run_traffic(input int n_items);
        logic [7:0] owners [8];
        logic [9:0] units;
        int         n_owners;
        int         ep_len;
        int         done;
        int         roll;
        int         k;
        done = 0;
        while (done < n_items) begin
            n_owners = $urandom_range(2, 8);
            for (k = 0; k < n_owners; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    owners[k] = 8'h00;
                end else if (roll < 16) begin
                    owners[k] = 8'hFF;
                end else begin
                    owners[k] = 8'($urandom_range(0, 255));
                end
            end
            ep_len = $urandom_range(20, 80);
            for (k = 0; k < ep_len && done < n_items; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70) begin
                        units = 10'($urandom_range(1, 32));
                    end else if (roll < 85) begin
                        units = 10'($urandom_range(33, 200));
                    end else if (roll < 92) begin
                        units = 10'($urandom_range(201, 512));
                    end else if (roll < 96) begin
                        units = 10'd0;
                    end else begin
                        units = 10'($urandom_range(513, 1023));
                    end
                    alloc_req(owners[$urandom_range(0, n_owners - 1)], units);
                end else if (roll < 90) begin
                    free_req(owners[$urandom_range(0, n_owners - 1)]);
                end else begin
                    free_req(8'($urandom_range(0, 255)));
                end
                done++;
            end
            for (k = 0; k < n_owners; k++) begin
                free_req(owners[k]);
                done++;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int gap;
        int holds_done;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_requests > holds_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // reset, stimulus phases and verdict
    initial begin : stimulus
        int drain_cycles;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_drained();

        // random gaps on both sides
        run_traffic(650);
        wait_drained();

        // back to back, no idling
        tx_max_gap = 0;
        rx_max_gap = 0;
        run_traffic(300);
        wait_drained();

        // receiver holds off while requests keep coming
        rx_max_gap = 12;
        hold_requests++;
        run_traffic(200);
        wait_drained();

        tx_max_gap = 12;
        run_traffic(550);

        // let every outstanding result come out
        in_valid <= 1'b0;
        drain_cycles = 0;
        @(posedge clk);
        while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d results checked", sent_count, checked);
        $display("outcomes seen: %0d grants, %0d releases, %0d refused on a full table",
                 grants, releases, fulls);
        if (pending != 0) begin
            $display("%0d results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
